[hdl/ffca_pkg.sv]
// Shared constants for the first-fit capacity allocator.
`default_nettype none

package ffca_pkg;

	// Slot count the design is built for unless overridden.
	localparam int SLOTS_DEFAULT = 1024;

	// Item field widths.
	localparam int SLOT_IDX_W = 10;
	localparam int AMOUNT_W   = 32;
	localparam int SLOT_NUM_W = 11;

	// Stream bus widths, padded to whole bytes.
	localparam int S_TDATA_W = 48;
	localparam int M_TDATA_W = 16;

	// Action codes carried in the input tuser.
	localparam logic ACT_LOAD  = 1'b0;
	localparam logic ACT_ALLOC = 1'b1;

endpackage

`default_nettype wire

[hdl/first_fit_capacity_allocator.sv]
// First-fit capacity allocator over a max segment tree held in one node RAM.
// Load item: accepted, then the leaf is written and each ancestor refreshed in turn.
// Allocate item: root check, descent to a leaf, leaf and ancestor update, then the result;
// a miss goes straight from the root check to the result. One tree node is read per cycle
// through the single RAM read port. Not ready while an item is in flight.
// Reset: async, active low; a clearing pass zeroes every tree node first.
`default_nettype none

module first_fit_capacity_allocator
	import ffca_pkg::*;
#(
	parameter int SLOTS = SLOTS_DEFAULT
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	// input items
	input  wire logic                 s_tvalid,
	output logic                      s_tready,
	input  wire logic [S_TDATA_W-1:0] s_tdata,  // [9:0] slot_index, [41:10] amount, rest zero
	input  wire logic                 s_tuser,  // [0] action
	// result items
	output logic                      m_tvalid,
	input  wire logic                 m_tready,
	output logic      [M_TDATA_W-1:0] m_tdata,  // [10:0] slot_number, rest zero
	output logic                      m_tuser   // [0] found
);

	// Tree geometry: leaves at LEAVES + slot, root at node 1.
	localparam int LVL_W      = (SLOTS > 1) ? $clog2(SLOTS) : 1;
	localparam int IDX_W      = LVL_W + 1;
	localparam int TREE_DEPTH = 1 << IDX_W;

	localparam logic [IDX_W-1:0] NODE_ROOT = IDX_W'(1);
	localparam logic [IDX_W-1:0] NODE_LEFT = IDX_W'(2);
	localparam logic [IDX_W-1:0] NODE_LAST = IDX_W'(TREE_DEPTH - 1);

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_CHK,
		ST_DESC,
		ST_LEAF,
		ST_UP,
		ST_DONE
	} state_t;

	state_t                  state_q;
	logic [IDX_W-1:0]        clr_q;
	logic [IDX_W-1:0]        node_q;
	logic [AMOUNT_W-1:0]     cur_q;
	logic [AMOUNT_W-1:0]     amt_q;
	logic                    alloc_q;
	logic                    res_found_q;
	logic [SLOT_NUM_W-1:0]   res_slot_q;
	logic                    out_valid_q;
	logic                    out_found_q;
	logic [SLOT_NUM_W-1:0]   out_slot_q;

	// Unpack the input item.
	logic [SLOT_IDX_W-1:0] in_slot;
	logic [AMOUNT_W-1:0]   in_amount;
	logic                  in_action;
	logic                  in_slot_ok;

	assign in_slot    = s_tdata[SLOT_IDX_W-1:0];
	assign in_amount  = s_tdata[SLOT_IDX_W +: AMOUNT_W];
	assign in_action  = s_tuser;
	assign in_slot_ok = 32'(in_slot) < 32'(SLOTS);

	// RAM ports.
	logic [IDX_W-1:0]    rd_addr;
	logic [AMOUNT_W-1:0] rd_data;
	logic                wr_en;
	logic [IDX_W-1:0]    wr_addr;
	logic [AMOUNT_W-1:0] wr_data;

	// Shared compare unit: node value against the request during the descent,
	// against the running maximum on the way back up.
	logic [AMOUNT_W-1:0] cmp_b;
	logic                ge;
	logic [AMOUNT_W-1:0] max_val;
	logic [AMOUNT_W-1:0] leaf_val;
	logic [IDX_W-1:0]    next_node;
	logic [IDX_W-1:0]    parent;
	logic                up_last;
	logic [SLOT_NUM_W-1:0] leaf_slot;

	assign cmp_b     = (state_q == ST_UP) ? cur_q : amt_q;
	assign ge        = rd_data >= cmp_b;
	assign max_val   = ge ? rd_data : cur_q;
	// Allocation subtracts from the leaf just read; a load overwrites it.
	assign leaf_val  = alloc_q ? (rd_data - amt_q) : amt_q;
	// Go left when the left child fits, otherwise right.
	assign next_node = {node_q[IDX_W-2:0], ~ge};
	assign parent    = {1'b0, node_q[IDX_W-1:1]};
	assign up_last   = parent == NODE_ROOT;
	assign leaf_slot = SLOT_NUM_W'({1'b0, node_q[LVL_W-1:0]} + (LVL_W + 1)'(1));

	// Read address: issued in the cycle before its use, since data comes back registered.
	always_comb begin
		unique case (state_q)
			ST_IDLE: rd_addr = NODE_ROOT;
			ST_CHK:  rd_addr = NODE_LEFT;
			ST_DESC: rd_addr = next_node[IDX_W-1] ? next_node
			                                      : {next_node[IDX_W-2:0], 1'b0};
			ST_LEAF: rd_addr = node_q ^ NODE_ROOT;  // sibling of the leaf
			ST_UP:   rd_addr = parent ^ NODE_ROOT;  // sibling of the parent
			default: rd_addr = NODE_ROOT;
		endcase
	end

	// Write port: clearing sweep, leaf update, ancestor refresh.
	always_comb begin
		unique case (state_q)
			ST_CLEAR: begin
				wr_en   = 1'b1;
				wr_addr = clr_q;
				wr_data = '0;
			end
			ST_LEAF: begin
				wr_en   = 1'b1;
				wr_addr = node_q;
				wr_data = leaf_val;
			end
			ST_UP: begin
				wr_en   = 1'b1;
				wr_addr = parent;
				wr_data = max_val;
			end
			default: begin
				wr_en   = 1'b0;
				wr_addr = node_q;
				wr_data = cur_q;
			end
		endcase
	end

	ffca_tree_ram #(
		.ADDR_W (IDX_W),
		.DATA_W (AMOUNT_W)
	) u_tree_ram (
		.clk     (clk),
		.rd_addr (rd_addr),
		.rd_data (rd_data),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_data)
	);

	// Sequencer and output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			clr_q       <= '0;
			node_q      <= '0;
			cur_q       <= '0;
			amt_q       <= '0;
			alloc_q     <= 1'b0;
			res_found_q <= 1'b0;
			res_slot_q  <= '0;
			out_valid_q <= 1'b0;
			out_found_q <= 1'b0;
			out_slot_q  <= '0;
		end else begin
			// Load a finished result when the output register is free;
			// drop the result once the sink takes it.
			if (state_q == ST_DONE && (!out_valid_q || m_tready)) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end

			unique case (state_q)
				ST_CLEAR: begin
					clr_q <= clr_q + IDX_W'(1);
					if (clr_q == NODE_LAST) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (s_tvalid) begin
						amt_q   <= in_amount;
						alloc_q <= in_action == ACT_ALLOC;
						if (in_action == ACT_ALLOC) begin
							state_q <= ST_CHK;
						end else if (in_slot_ok) begin
							node_q  <= {1'b1, LVL_W'(in_slot)};
							state_q <= ST_LEAF;
						end
					end
				end
				ST_CHK: begin
					// Root holds the overall maximum: miss when even that is short.
					if (!ge) begin
						res_found_q <= 1'b0;
						res_slot_q  <= '0;
						state_q     <= ST_DONE;
					end else begin
						node_q  <= NODE_ROOT;
						state_q <= ST_DESC;
					end
				end
				ST_DESC: begin
					node_q <= next_node;
					if (next_node[IDX_W-1]) begin
						state_q <= ST_LEAF;
					end
				end
				ST_LEAF: begin
					cur_q       <= leaf_val;
					res_found_q <= 1'b1;
					res_slot_q  <= leaf_slot;
					state_q     <= ST_UP;
				end
				ST_UP: begin
					cur_q  <= max_val;
					node_q <= parent;
					if (up_last) begin
						state_q <= alloc_q ? ST_DONE : ST_IDLE;
					end
				end
				ST_DONE: begin
					// Hold until the output register is free.
					if (!out_valid_q || m_tready) begin
						out_found_q <= res_found_q;
						out_slot_q  <= res_slot_q;
						state_q     <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign s_tready = state_q == ST_IDLE;
	assign m_tvalid = out_valid_q;
	assign m_tuser  = out_found_q;
	assign m_tdata  = {{(M_TDATA_W - SLOT_NUM_W){1'b0}}, out_slot_q};

`ifndef ASSERT_OFF
	// A miss always reports slot number zero.
	a_miss_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !out_found_q) |-> (out_slot_q == '0))
		else $error("miss result carries a nonzero slot number");

	// The descent never walks past the leaf level.
	a_desc_inner: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DESC) |-> !node_q[IDX_W-1])
		else $error("descent node left the inner levels");

	// The leaf stage only ever addresses a leaf.
	a_leaf_node: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_LEAF) |-> node_q[IDX_W-1])
		else $error("leaf update addressed an inner node");

	// A result is only pushed from the finishing state.
	a_push_done: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> ($past(state_q) == ST_DONE))
		else $error("result pushed outside the finishing state");
`endif

endmodule

`default_nettype wire

[hdl/ffca_tree_ram.sv]
// Single-port-write, registered-read node store for the max tree.
`default_nettype none

module ffca_tree_ram
	import ffca_pkg::*;
#(
	parameter int ADDR_W = 11,
	parameter int DATA_W = AMOUNT_W
) (
	input  wire logic              clk,
	input  wire logic [ADDR_W-1:0] rd_addr,
	output logic      [DATA_W-1:0] rd_data,
	input  wire logic              wr_en,
	input  wire logic [ADDR_W-1:0] wr_addr,
	input  wire logic [DATA_W-1:0] wr_data
);

	localparam int DEPTH = 1 << ADDR_W;

	logic [DATA_W-1:0] mem_q [DEPTH];
	logic [DATA_W-1:0] rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		rd_data_q <= mem_q[rd_addr];
	end

	assign rd_data = rd_data_q;

endmodule

`default_nettype wire

[tb/testbench.sv]
// Self-checking testbench for first_fit_capacity_allocator: predicts each result, checks the stream.
`default_nettype none

module testbench;
	import ffca_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int SLOTS = SLOTS_DEFAULT;
	localparam int LEAVES = 1 << $clog2(SLOTS);
	// Allow for the longest allocate and a trailing load too.
	localparam int SETTLE_CYCLES = 4 * $clog2(LEAVES) + 16;
	// Clearing pass plus every item at its slowest, several times over.
	localparam int CYCLE_LIMIT = 400000;
	localparam int RANDOM_ITEMS = 650;

	typedef struct packed {
		logic        action;
		logic [9:0]  slot_index;
		logic [31:0] amount;
	} request_t;

	typedef struct packed {
		logic        found;
		logic [10:0] slot_number;
	} grant_t;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 s_tvalid = 1'b0;
	logic                 s_tready;
	logic [S_TDATA_W-1:0] s_tdata = '0;  // [9:0] slot_index, [41:10] amount, rest zero
	logic                 s_tuser = ACT_LOAD;  // [0] action
	logic                 m_tvalid;
	logic                 m_tready = 1'b0;
	logic [M_TDATA_W-1:0] m_tdata;  // [10:0] slot_number, rest zero
	logic                 m_tuser;  // [0] found

	// Items still to be offered to the block, filled once at time zero.
	request_t request_q[$];
	// Grants owed by the block, oldest first.
	grant_t grants_due[$];
	// Our own copy of the capacity tree: root at 1, children of k at 2k and 2k+1.
	logic [31:0] cap_tree[2*LEAVES];

	int total_items = 1;
	int accepted_items = 0;
	int error_count = 0;
	int cycle_count = 0;

	first_fit_capacity_allocator #(
		.SLOTS(SLOTS)
	) uut (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata (s_tdata),
		.s_tuser (s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata (m_tdata),
		.m_tuser (m_tuser)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	// Walk from a changed leaf to the root, each node the max of its children.
	function automatic void refresh_ancestors(input int unsigned leaf);
		int unsigned node;
		node = leaf;
		while (node > 1) begin
			node = node >> 1;
			cap_tree[node] = (cap_tree[2*node] > cap_tree[2*node+1]) ?
				cap_tree[2*node] : cap_tree[2*node+1];
		end
	endfunction

	// Apply one accepted item to the tree and queue the grant it owes, if any.
	function automatic void predict_request(input logic act, input logic [9:0] slot,
			input logic [31:0] amt);
		int unsigned node;
		grant_t g;
		if (act == ACT_LOAD) begin
			// loads past the slot count are dropped
			if (int'(slot) < SLOTS) begin
				node = LEAVES + slot;
				cap_tree[node] = amt;
				refresh_ancestors(node);
			end
		end else begin
			if (cap_tree[1] < amt) begin
				// nothing fits: tree untouched
				g.found = 1'b0;
				g.slot_number = '0;
			end else begin
				// descend, preferring the left child so the lowest slot wins ties
				node = 1;
				while (node < LEAVES)
					node = (cap_tree[2*node] >= amt) ? 2*node : 2*node + 1;
				cap_tree[node] = cap_tree[node] - amt;
				refresh_ancestors(node);
				g.found = 1'b1;
				g.slot_number = 11'(node - LEAVES + 1);
			end
			grants_due.push_back(g);
		end
	endfunction

	// Idle odds in percent: receiver-heavy, then sender-heavy, then none.
	function automatic int sender_idle_pct();
		case ((accepted_items * 3) / total_items)
			0: return 33;
			1: return 54;
			default: return 0;
		endcase
	endfunction

	function automatic int receiver_idle_pct();
		case ((accepted_items * 3) / total_items)
			0: return 54;
			1: return 33;
			default: return 0;
		endcase
	endfunction

	function automatic request_t make_request(input logic act, input int unsigned slot,
			input logic [31:0] amt);
		request_t r;
		r.action = act;
		r.slot_index = 10'(slot);
		r.amount = amt;
		return r;
	endfunction

	// Driver: predict on each accepted item, then offer the next one or idle.
	always @(posedge clk or negedge arst_n) begin
		request_t next_req;
		if (!arst_n) begin
			s_tvalid <= 1'b0;
			s_tdata <= '0;
			s_tuser <= ACT_LOAD;
		end else begin
			if (s_tvalid && s_tready) begin
				predict_request(s_tuser, s_tdata[9:0], s_tdata[41:10]);
				accepted_items++;
			end
			if (!s_tvalid || s_tready) begin
				if (request_q.size() != 0 && $urandom_range(99) >= sender_idle_pct()) begin
					next_req = request_q.pop_front();
					s_tvalid <= 1'b1;
					s_tdata <= {6'b0, next_req.amount, next_req.slot_index};
					s_tuser <= next_req.action;
				end else begin
					s_tvalid <= 1'b0;
				end
			end
		end
	end

	// Monitor: compare each grant with the oldest one owed, then stall at random.
	always @(posedge clk or negedge arst_n) begin
		grant_t want;
		if (!arst_n) begin
			m_tready <= 1'b0;
		end else begin
			if (m_tvalid && m_tready) begin
				if (grants_due.size() == 0) begin
					$display("%0t: expected no item, got found=%0b slot_number=%0d",
						$time, m_tuser, m_tdata);
					error_count++;
				end else begin
					want = grants_due.pop_front();
					if (m_tuser !== want.found ||
							m_tdata !== {{(M_TDATA_W-11){1'b0}}, want.slot_number}) begin
						$display("%0t: expected found=%0b slot_number=%0d, got found=%0b slot_number=%0d",
							$time, want.found, want.slot_number, m_tuser, m_tdata);
						error_count++;
					end
				end
			end
			m_tready <= ($urandom_range(99) >= receiver_idle_pct());
		end
	end

	// Watchdog: a hung block fails the run.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("first_fit_capacity_allocator: mismatch");
			$finish;
		end
	end

	initial begin
		int unsigned pick;
		logic [31:0] amt;
		int unsigned slot;

		for (int i = 0; i < 2*LEAVES; i++)
			cap_tree[i] = '0;

		// Directed: empty tree, extremes, ties, zero amount.
		request_q.push_back(make_request(ACT_ALLOC, 0, 32'd0));          // zero amount on empty tree
		request_q.push_back(make_request(ACT_ALLOC, 0, 32'd1));          // miss on empty tree
		request_q.push_back(make_request(ACT_ALLOC, 1023, 32'hFFFF_FFFF));
		request_q.push_back(make_request(ACT_LOAD, 0, 32'hFFFF_FFFF));
		request_q.push_back(make_request(ACT_LOAD, 1023, 32'd100));
		request_q.push_back(make_request(ACT_LOAD, 512, 32'd50));
		request_q.push_back(make_request(ACT_ALLOC, 0, 32'hFFFF_FFFF));  // drains slot 0
		request_q.push_back(make_request(ACT_ALLOC, 0, 32'd60));         // last slot
		request_q.push_back(make_request(ACT_ALLOC, 0, 32'd40));         // slot 512 before 1023
		request_q.push_back(make_request(ACT_LOAD, 511, 32'd40));
		request_q.push_back(make_request(ACT_ALLOC, 0, 32'd40));         // tie: 511 over 1023
		request_q.push_back(make_request(ACT_ALLOC, 0, 32'd40));         // only 1023 fits now
		request_q.push_back(make_request(ACT_ALLOC, 0, 32'd0));          // zero amount, slot 0 empty
		request_q.push_back(make_request(ACT_ALLOC, 0, 32'd41));         // miss
		request_q.push_back(make_request(ACT_LOAD, 341, 32'hAAAA_AAAA));
		request_q.push_back(make_request(ACT_LOAD, 682, 32'h5555_5555));
		request_q.push_back(make_request(ACT_ALLOC, 682, 32'h5555_5556)); // slot 341, remainder
		request_q.push_back(make_request(ACT_ALLOC, 0, 32'h5555_5555));  // slot 682 drained exactly
		request_q.push_back(make_request(ACT_ALLOC, 0, 32'h5555_5555));  // miss: slot 341 is one short
		request_q.push_back(make_request(ACT_LOAD, 0, 32'd0));

		// Random: loads and allocates mixed, slots often crowded near zero.
		for (int i = 0; i < RANDOM_ITEMS; i++) begin
			pick = $urandom_range(99);
			slot = ($urandom_range(1) == 0) ? $urandom_range(15) : $urandom_range(1023);
			if (pick < 45) begin
				pick = $urandom_range(99);
				amt = (pick < 70) ? 32'($urandom_range(2000, 1)) :
					(pick < 90) ? $urandom : 32'd0;
				request_q.push_back(make_request(ACT_LOAD, slot, amt));
			end else begin
				pick = $urandom_range(99);
				amt = (pick < 70) ? 32'($urandom_range(1500, 1)) :
					(pick < 80) ? 32'd0 : $urandom;
				request_q.push_back(make_request(ACT_ALLOC, slot, amt));
			end
		end
		total_items = request_q.size();

		// Hold reset, then release at a rising edge.
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;

		do @(negedge clk); while (request_q.size() != 0 || s_tvalid);
		do @(negedge clk); while (grants_due.size() != 0);
		// Let a trailing load finish and catch any stray result.
		repeat (SETTLE_CYCLES) @(negedge clk);

		if (error_count == 0) begin
			$display("first_fit_capacity_allocator: match");
		end else begin
			$display("first_fit_capacity_allocator: mismatch");
		end
		$finish;
	end

endmodule

`default_nettype wire

[filelist.f]
hdl/ffca_pkg.sv
hdl/ffca_tree_ram.sv
hdl/first_fit_capacity_allocator.sv
tb/testbench.sv
